### design/rau_pkg.sv
// Package: shared types, command codes and controller states of the rational arithmetic unit.
package rau_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int PROD_WIDTH  = 2 * VALUE_WIDTH + 2;
	localparam int MAG_WIDTH   = PROD_WIDTH - 1;
	localparam int CNT_WIDTH   = $clog2(MAG_WIDTH + 1);

	typedef enum logic [2:0] {
		CMD_LOAD    = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_SUB     = 3'd2,
		CMD_MUL     = 3'd3,
		CMD_DIV     = 3'd4,
		CMD_COMPARE = 3'd5,
		CMD_RSVD6   = 3'd6,
		CMD_RSVD7   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ZERO     = 2'd1,
		STAT_OVERFLOW = 2'd2,
		STAT_RSVD     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] operand_num;
		logic signed [31:0] operand_den;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] acc_num;
		logic signed [31:0] acc_den;
		logic               is_smaller;
		logic               is_equal;
		logic [1:0]         status;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FORM,
		ST_GCD_INIT,
		ST_GCD_DIV,
		ST_GCD_STEP,
		ST_RED_NUM,
		ST_RED_DEN,
		ST_FINISH,
		ST_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic       capture;
		logic [1:0] mul_sel;
		logic       form;
		logic       gcd_init;
		logic       div_start;
		logic [1:0] div_sel;
		logic       gcd_step;
		logic       red_num;
		logic       finish;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic arith;
		logic zero_zero;
		logic b_zero;
		logic div_done;
	} dp_stat_t;

endpackage

### design/rau_divider.sv
// Restoring divider: unsigned magnitude quotient and remainder, one bit per cycle.
module rau_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [rau_pkg::MAG_WIDTH-1:0]        dividend,
	input  logic [rau_pkg::MAG_WIDTH-1:0]        divisor,
	output logic                                 done,
	output logic [rau_pkg::MAG_WIDTH-1:0]        quotient,
	output logic [rau_pkg::MAG_WIDTH-1:0]        remainder
);

	logic [rau_pkg::MAG_WIDTH-1:0] quo_q;
	logic [rau_pkg::MAG_WIDTH-1:0] rem_q;
	logic [rau_pkg::MAG_WIDTH-1:0] dvs_q;
	logic [rau_pkg::CNT_WIDTH-1:0] cnt_q;
	logic                          busy_q;
	logic [rau_pkg::MAG_WIDTH:0]   trial;
	logic [rau_pkg::MAG_WIDTH:0]   diff;

	assign trial = {rem_q, quo_q[rau_pkg::MAG_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= rau_pkg::CNT_WIDTH'(rau_pkg::MAG_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == rau_pkg::CNT_WIDTH'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[rau_pkg::MAG_WIDTH]) begin
				rem_q <= diff[rau_pkg::MAG_WIDTH-1:0];
				quo_q <= {quo_q[rau_pkg::MAG_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[rau_pkg::MAG_WIDTH-1:0];
				quo_q <= {quo_q[rau_pkg::MAG_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done      = !busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### design/rau_datapath.sv
// Datapath: accumulator, shared multiplier, GCD registers, reduction and compare.
module rau_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::in_word_t   in_word,
	input  rau_pkg::dp_cmd_t    cmd,
	output rau_pkg::dp_stat_t   stat,
	output rau_pkg::out_word_t  result
);

	localparam int W  = rau_pkg::VALUE_WIDTH;
	localparam int PW = rau_pkg::PROD_WIDTH;
	localparam int MW = rau_pkg::MAG_WIDTH;

	logic signed [W-1:0]  hn_q, hd_q, on_q, od_q;
	rau_pkg::cmd_t        cmd_q;
	logic signed [2*W-1:0] p1_q, p2_q, p3_q;
	logic signed [PW-1:0] n_q, d_q;
	logic [MW-1:0]        a_q, b_q;
	logic [W-1:0]         rn_q;
	rau_pkg::out_word_t   res_q;

	logic signed [W-1:0]   mul_a, mul_b;
	logic signed [2*W-1:0] prod;
	logic [MW-1:0]         div_dividend, div_divisor, quo, rem;
	logic                  div_done;
	logic [MW-1:0]         n_mag, d_mag;
	logic signed [PW-1:0]  n_new, d_new;
	logic                  arith;

	// one shared signed multiplier, registered output
	always_comb begin
		unique case (cmd.mul_sel)
			2'd0: begin mul_a = hn_q; mul_b = od_q; end
			2'd1: begin
				mul_a = (cmd_q == rau_pkg::CMD_MUL) ? hn_q : on_q;
				mul_b = (cmd_q == rau_pkg::CMD_MUL) ? on_q : hd_q;
			end
			2'd2: begin
				mul_a = hd_q;
				mul_b = (cmd_q == rau_pkg::CMD_DIV) ? on_q : od_q;
			end
			default: begin mul_a = hn_q; mul_b = od_q; end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign arith = (cmd_q == rau_pkg::CMD_LOAD) || (cmd_q == rau_pkg::CMD_ADD) ||
		(cmd_q == rau_pkg::CMD_SUB) || (cmd_q == rau_pkg::CMD_MUL) ||
		(cmd_q == rau_pkg::CMD_DIV);

	always_comb begin
		unique case (cmd_q)
			rau_pkg::CMD_LOAD: begin
				n_new = PW'(on_q);
				d_new = PW'(od_q);
			end
			rau_pkg::CMD_ADD: begin
				n_new = PW'(p1_q) + PW'(p2_q);
				d_new = PW'(p3_q);
			end
			rau_pkg::CMD_SUB: begin
				n_new = PW'(p1_q) - PW'(p2_q);
				d_new = PW'(p3_q);
			end
			rau_pkg::CMD_MUL: begin
				n_new = PW'(p2_q);
				d_new = PW'(p3_q);
			end
			rau_pkg::CMD_DIV: begin
				n_new = PW'(p1_q);
				d_new = PW'(p3_q);
			end
			default: begin
				n_new = '0;
				d_new = '0;
			end
		endcase
	end

	assign n_mag = n_q[PW-1] ? MW'(-n_q) : MW'(n_q);
	assign d_mag = d_q[PW-1] ? MW'(-d_q) : MW'(d_q);

	// divider serves GCD steps and both reductions
	always_comb begin
		unique case (cmd.div_sel)
			2'd0:    begin div_dividend = a_q;   div_divisor = b_q; end
			2'd1:    begin div_dividend = n_mag; div_divisor = a_q; end
			2'd2:    begin div_dividend = d_mag; div_divisor = a_q; end
			default: begin div_dividend = a_q;   div_divisor = b_q; end
		endcase
	end

	rau_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	// compare helpers
	logic [1:0] ca, cb;
	logic       lt, eq, neg;
	always_comb begin
		ca = (hd_q != 0) ? 2'd1 : (!hn_q[W-1] && hn_q != 0) ? 2'd2 : hn_q[W-1] ? 2'd0 : 2'd3;
		cb = (od_q != 0) ? 2'd1 : (!on_q[W-1] && on_q != 0) ? 2'd2 : on_q[W-1] ? 2'd0 : 2'd3;
		neg = hd_q[W-1] != od_q[W-1];
		lt = 1'b0;
		eq = 1'b0;
		if (ca == 2'd3 || cb == 2'd3) begin
			lt = 1'b0;
		end else if (ca == 2'd1 && cb == 2'd1) begin
			eq = p1_q == p2_q;
			lt = neg ? (p1_q > p2_q) : (p1_q < p2_q);
		end else begin
			lt = ca < cb;
			eq = ca == cb;
		end
	end

	logic signed [W-1:0] rn_s, rd_s;
	logic                ovf;
	always_comb begin
		rn_s = n_q[PW-1] ? W'(-rn_q) : W'(rn_q);
		rd_s = d_q[PW-1] ? W'(-quo) : W'(quo);
		ovf  = n_q[PW-1] ? (rn_q > (W'(1) << (W - 1))) : rn_q[W-1];
		if (quo[MW-1:W] != '0)
			ovf = 1'b1;
		if (d_q[PW-1] ? (quo[W-1:0] > (W'(1) << (W - 1))) : quo[W-1])
			ovf = 1'b1;
	end

	logic num_hi;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hn_q   <= '0;
			hd_q   <= W'(1);
			num_hi <= 1'b0;
		end else begin
			if (cmd.red_num)
				num_hi <= quo[MW-1:W] != '0;
			if (cmd.finish && arith && !(n_q == 0 && d_q == 0) && !(ovf || num_hi)) begin
				hn_q <= rn_s;
				hd_q <= rd_s;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= rau_pkg::cmd_t'(in_word.command);
			on_q  <= in_word.operand_num[W-1:0];
			od_q  <= in_word.operand_den[W-1:0];
		end
		unique case (cmd.mul_sel)
			2'd0: p1_q <= prod;
			2'd1: p2_q <= prod;
			2'd2: p3_q <= prod;
			default: p3_q <= p3_q;
		endcase
		if (cmd.form) begin
			n_q <= n_new;
			d_q <= d_new;
		end
		if (cmd.gcd_init) begin
			a_q <= n_mag;
			b_q <= d_mag;
		end
		if (cmd.gcd_step) begin
			a_q <= b_q;
			b_q <= rem;
		end
		if (cmd.red_num)
			rn_q <= quo[W-1:0];
		if (cmd.finish) begin
			res_q.is_smaller <= (cmd_q == rau_pkg::CMD_COMPARE) && lt;
			res_q.is_equal   <= (cmd_q == rau_pkg::CMD_COMPARE) && eq;
			if (!arith) begin
				res_q.status  <= rau_pkg::STAT_OK;
				res_q.acc_num <= hn_q;
				res_q.acc_den <= hd_q;
			end else if (n_q == 0 && d_q == 0) begin
				res_q.status  <= rau_pkg::STAT_ZERO;
				res_q.acc_num <= hn_q;
				res_q.acc_den <= hd_q;
			end else if (ovf || num_hi) begin
				res_q.status  <= rau_pkg::STAT_OVERFLOW;
				res_q.acc_num <= hn_q;
				res_q.acc_den <= hd_q;
			end else begin
				res_q.status  <= rau_pkg::STAT_OK;
				res_q.acc_num <= rn_s;
				res_q.acc_den <= rd_s;
			end
		end
	end

	assign stat.arith     = arith;
	assign stat.zero_zero = (n_q == 0) && (d_q == 0);
	assign stat.b_zero    = (b_q == '0);
	assign stat.div_done  = div_done;
	assign result         = res_q;

endmodule

### design/rau_ctrl.sv
// Controller: sequences capture, products, GCD loop, reduction and output handshake.
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rau_pkg::dp_stat_t stat,
	output rau_pkg::dp_cmd_t  cmd
);

	rau_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rau_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = 2'd3;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		unique case (state_q)
			rau_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = rau_pkg::ST_MUL1;
				end
			end
			rau_pkg::ST_MUL1: begin cmd.mul_sel = 2'd0; state_d = rau_pkg::ST_MUL2; end
			rau_pkg::ST_MUL2: begin cmd.mul_sel = 2'd1; state_d = rau_pkg::ST_MUL3; end
			rau_pkg::ST_MUL3: begin cmd.mul_sel = 2'd2; state_d = rau_pkg::ST_FORM; end
			rau_pkg::ST_FORM: begin cmd.form = 1'b1; state_d = rau_pkg::ST_GCD_INIT; end
			rau_pkg::ST_GCD_INIT: begin
				if (!stat.arith || stat.zero_zero) begin
					state_d = rau_pkg::ST_FINISH;
				end else begin
					cmd.gcd_init = 1'b1;
					state_d = rau_pkg::ST_GCD_STEP;
				end
			end
			rau_pkg::ST_GCD_STEP: begin
				if (stat.b_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = 2'd1;
					state_d = rau_pkg::ST_RED_NUM;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = 2'd0;
					state_d = rau_pkg::ST_GCD_DIV;
				end
			end
			rau_pkg::ST_GCD_DIV: begin
				if (stat.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d = rau_pkg::ST_GCD_STEP;
				end
			end
			rau_pkg::ST_RED_NUM: begin
				if (stat.div_done) begin
					cmd.red_num   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = 2'd2;
					state_d = rau_pkg::ST_RED_DEN;
				end
			end
			rau_pkg::ST_RED_DEN: begin
				if (stat.div_done)
					state_d = rau_pkg::ST_FINISH;
			end
			rau_pkg::ST_FINISH: begin cmd.finish = 1'b1; state_d = rau_pkg::ST_OUT; end
			rau_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = rau_pkg::ST_IDLE;
			end
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end

endmodule

### design/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: controller, datapath and assertions.
//
//  channel  direction  handshake            word
//  in       sink       in_valid / in_stall  rau_pkg::in_word_t
//  out      source     out_valid/ out_stall rau_pkg::out_word_t
//
// One word at a time. Capture, three multiplies on one shared 32x32 multiplier,
// form, then a Euclidean GCD where each remainder takes a step state and a pass
// through the bit-serial divider, then two more divider passes reduce numerator
// and denominator. Compare, unused commands and zero over zero skip the divisions.
// Reset gives accumulator 0/1. A stalled result holds in the output register.
module rational_arithmetic_unit_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rau_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output rau_pkg::out_word_t out_word
);

	rau_pkg::dp_cmd_t  cmd;
	rau_pkg::dp_stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rau_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (in_word),
		.cmd     (cmd),
		.stat    (stat),
		.result  (out_word)
	);

	// never take a word while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	// a result never reports a status code outside the defined set
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.status != rau_pkg::STAT_RSVD))
		else $error("bad status");

	// the flags only appear with ok status
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_word.is_smaller || out_word.is_equal)) |->
		(out_word.status == rau_pkg::STAT_OK))
		else $error("flags with fault");

endmodule

### tb/rational_arithmetic_unit_top_tb.sv
// Testbench for the rational arithmetic unit: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module rational_arithmetic_unit_top_tb;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	rau_pkg::in_word_t  in_word = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	rau_pkg::out_word_t out_word;

	rational_arithmetic_unit_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	always #2 clk = ~clk;

	// Words waiting to be offered, and the results the predictor expects.
	rau_pkg::in_word_t  pending_words[$];
	rau_pkg::out_word_t expected_results[$];
	int        mismatch_count = 0;
	int        accepted_count = 0;
	int        result_count = 0;
	int        op_seen[8];
	int        stat_seen[4];
	bit        stimulus_done = 1'b0;
	bit        hold_off_req = 1'b0;
	bit        hold_off_active = 1'b0;

	// Predictor copy of the accumulator.
	longint acc_n = 0;
	longint acc_d = 1;

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Order class: 0 minus infinity, 1 finite, 2 plus infinity, 3 unordered.
	function automatic int order_class(longint n, longint d);
		if (d != 0) return 1;
		if (n > 0) return 2;
		if (n < 0) return 0;
		return 3;
	endfunction

	// Apply one word to the accumulator and return the result word.
	function automatic rau_pkg::out_word_t apply_fraction_step(rau_pkg::in_word_t w);
		rau_pkg::out_word_t r;
		longint on, od, n, d, rn, rd, lhs, rhs;
		longint unsigned a, b, t;
		bit do_arith;
		int ca, cb;
		on = longint'(w.operand_num);
		od = longint'(w.operand_den);
		n = 0;
		d = 0;
		do_arith = 1'b1;
		r = '0;
		r.status = rau_pkg::STAT_OK;
		case (rau_pkg::cmd_t'(w.command))
			rau_pkg::CMD_LOAD: begin n = on; d = od; end
			rau_pkg::CMD_ADD: begin n = acc_n * od + on * acc_d; d = acc_d * od; end
			rau_pkg::CMD_SUB: begin n = acc_n * od - on * acc_d; d = acc_d * od; end
			rau_pkg::CMD_MUL: begin n = acc_n * on; d = acc_d * od; end
			rau_pkg::CMD_DIV: begin n = acc_n * od; d = acc_d * on; end
			rau_pkg::CMD_COMPARE: begin
				do_arith = 1'b0;
				ca = order_class(acc_n, acc_d);
				cb = order_class(on, od);
				if (ca != 3 && cb != 3) begin
					if (ca == 1 && cb == 1) begin
						lhs = acc_n * od;
						rhs = on * acc_d;
						r.is_equal = (lhs == rhs);
						// Flip the ordering when exactly one denominator is negative.
						r.is_smaller = ((acc_d < 0) != (od < 0)) ? (lhs > rhs) : (lhs < rhs);
					end else begin
						r.is_smaller = ca < cb;
						r.is_equal = ca == cb;
					end
				end
			end
			default: do_arith = 1'b0;
		endcase
		if (do_arith) begin
			if (n == 0 && d == 0) begin
				r.status = rau_pkg::STAT_ZERO;
			end else begin
				a = magnitude(n);
				b = magnitude(d);
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				rn = (n < 0) ? -longint'(magnitude(n) / a) : longint'(magnitude(n) / a);
				rd = (d < 0) ? -longint'(magnitude(d) / a) : longint'(magnitude(d) / a);
				if (rn < -64'sd2147483648 || rn > 64'sd2147483647 ||
				    rd < -64'sd2147483648 || rd > 64'sd2147483647) begin
					r.status = rau_pkg::STAT_OVERFLOW;
				end else begin
					acc_n = rn;
					acc_d = rd;
				end
			end
		end
		r.acc_num = acc_n[31:0];
		r.acc_den = acc_d[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatch_count++;
		$display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got, want);
	endtask

	function automatic rau_pkg::in_word_t make_word(rau_pkg::cmd_t c, int n, int d);
		rau_pkg::in_word_t w;
		w.command = c;
		w.operand_num = n;
		w.operand_den = d;
		return w;
	endfunction

	// Pick a small, mid or full-range operand so results reduce and overflow alike.
	function automatic int pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 24) - 12;
			4, 5, 6: return $urandom_range(0, 2000) - 1000;
			7: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	// Driver: offer the next pending word after a random gap; hold while stalled.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (in_valid && in_stall) begin
			// hold the word
		end else begin
			if (in_valid) begin
				// Word accepted this edge: predict its result now.
				expected_results.push_back(apply_fraction_step(in_word));
				accepted_count++;
				op_seen[in_word.command]++;
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_word <= pending_words.pop_front();
				in_valid <= 1'b1;
				send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long hold-off of the result side, counted here in clock cycles.
	initial begin
		wait (hold_off_req);
		@(posedge clk);
		hold_off_active <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_off_active <= 1'b0;
	end

	// Monitor: check each accepted result, then draw the next stall.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		rau_pkg::out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("unexpected result word with nothing pending");
				end else begin
					want = expected_results.pop_front();
					stat_seen[want.status]++;
					if (out_word.acc_num !== want.acc_num)
						report_mismatch("acc_num", out_word.acc_num, want.acc_num);
					if (out_word.acc_den !== want.acc_den)
						report_mismatch("acc_den", out_word.acc_den, want.acc_den);
					if (out_word.is_smaller !== want.is_smaller)
						report_mismatch("is_smaller", out_word.is_smaller, want.is_smaller);
					if (out_word.is_equal !== want.is_equal)
						report_mismatch("is_equal", out_word.is_equal, want.is_equal);
					if (out_word.status !== want.status)
						report_mismatch("status", out_word.status, want.status);
				end
			end
			// Long hold-off takes priority so the input side backs up.
			if (hold_off_active) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
			end
		end
	end

	// Stimulus.
	initial begin
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every command, range extremes and the special cases.
		pending_words.push_back(make_word(rau_pkg::CMD_COMPARE, 0, 1));
		pending_words.push_back(make_word(rau_pkg::CMD_LOAD, 6, -4));
		pending_words.push_back(make_word(rau_pkg::CMD_ADD, 1, 3));
		pending_words.push_back(make_word(rau_pkg::CMD_SUB, -5, 7));
		pending_words.push_back(make_word(rau_pkg::CMD_MUL, 3, -2));
		pending_words.push_back(make_word(rau_pkg::CMD_DIV, 9, 5));
		pending_words.push_back(make_word(rau_pkg::CMD_COMPARE, 1, 1));
		pending_words.push_back(make_word(rau_pkg::CMD_LOAD, 0, 0));      // zero over zero
		pending_words.push_back(make_word(rau_pkg::CMD_LOAD, 5, 0));      // reduces to +1/0
		pending_words.push_back(make_word(rau_pkg::CMD_COMPARE, 7, 0));   // equal infinities
		pending_words.push_back(make_word(rau_pkg::CMD_COMPARE, -3, 0));
		pending_words.push_back(make_word(rau_pkg::CMD_COMPARE, 0, 0));   // unordered
		pending_words.push_back(make_word(rau_pkg::CMD_ADD, 1, 0));
		pending_words.push_back(make_word(rau_pkg::CMD_LOAD, 32'sh7fffffff, 32'sh80000000));
		pending_words.push_back(make_word(rau_pkg::CMD_COMPARE, 32'sh80000000, 32'sh7fffffff));
		pending_words.push_back(make_word(rau_pkg::CMD_MUL, 32'sh7fffffff, 1)); // overflow
		pending_words.push_back(make_word(rau_pkg::CMD_ADD, 32'sh80000000, 32'sh80000000));
		pending_words.push_back(make_word(rau_pkg::CMD_LOAD, 32'sh80000000, -1)); // most negative numerator still fits
		pending_words.push_back(make_word(rau_pkg::CMD_LOAD, -7, -14));
		pending_words.push_back(make_word(rau_pkg::CMD_COMPARE, 1, -2));
		pending_words.push_back(make_word(rau_pkg::CMD_RSVD6, 3, 4));
		pending_words.push_back(make_word(rau_pkg::CMD_RSVD7, -1, -1));
		pending_words.push_back(make_word(rau_pkg::CMD_DIV, 0, 3));
		pending_words.push_back(make_word(rau_pkg::CMD_DIV, 0, 0));

		// Random words; loads keep the accumulator small so the arithmetic stays deep.
		for (i = 0; i < 1250; i++) begin
			rau_pkg::cmd_t c;
			c = ($urandom_range(0, 5) == 0) ? rau_pkg::CMD_LOAD :
				rau_pkg::cmd_t'($urandom_range(0, 7));
			if ($urandom_range(0, 40) == 0) c = rau_pkg::cmd_t'($urandom_range(6, 7));
			else if (c > rau_pkg::CMD_COMPARE) c = rau_pkg::cmd_t'($urandom_range(1, 5));
			pending_words.push_back(make_word(c, pick_operand(), pick_operand()));
			// Once, partway, hold the result side off so the block backs up.
			if (i == 400) begin
				wait (pending_words.size() < 300);
				hold_off_req = 1'b1;
			end
		end

		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		stimulus_done = 1'b1;
		repeat (2000) @(posedge clk);
		$display("covered %0d words: load %0d add %0d sub %0d mul %0d div %0d compare %0d",
			accepted_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
			op_seen[5]);
		$display("unused commands %0d; results ok %0d, zero over zero %0d, overflow %0d",
			op_seen[6] + op_seen[7], stat_seen[0], stat_seen[1], stat_seen[2]);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog: a full run, even with the longest GCD and stalls, stays well below this.
	initial begin
		#200_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("status: fail");
		$finish;
	end

endmodule
